// ===== rtl/sas_pkg.sv =====
// shared types and constants for the sorted set array unit
package sas_pkg;

    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;

    localparam int S_FIELDS_W = CMD_W + KEY_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + POS_W + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2
    } sas_cmd_t;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;

    // strobes broadcast from the top level to every cell
    typedef struct packed {
        logic capture;
        logic insert;
        logic remove;
    } sas_ctrl_t;

endpackage

// ===== rtl/sas_cell.sv =====
// one storage cell of the sorted chain: holds an entry, compares, shifts
module sas_cell import sas_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  sas_ctrl_t        ctrl,
    input  logic [KEY_W-1:0] key,
    input  logic [KEY_W-1:0] left_value,
    input  logic             left_valid,
    input  logic             left_lt,
    input  logic [KEY_W-1:0] right_value,
    input  logic             right_valid,
    output logic [KEY_W-1:0] value,
    output logic             valid,
    output logic             lt,
    output logic             boundary,
    output logic             eq
);

    logic [KEY_W-1:0] value_reg, value_next;
    logic             valid_reg, valid_next;
    logic             lt_reg, lt_next;
    logic             eq_reg, eq_next;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (ctrl.capture) begin
            lt_next = valid_reg && ($signed(value_reg) < $signed(key));
            eq_next = valid_reg && (value_reg == key);
        end
        // insert: entries at or above the slot move up, the slot takes the key
        if (ctrl.insert && !lt_reg) begin
            if (left_lt) begin
                value_next = key;
                valid_next = 1'b1;
            end else begin
                value_next = left_value;
                valid_next = left_valid;
            end
        end
        // remove: entries at or above the hit move down
        if (ctrl.remove && !lt_reg) begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign value    = value_reg;
    assign valid    = valid_reg;
    assign lt       = lt_reg;
    assign boundary = !lt_reg && left_lt;
    assign eq       = eq_reg;

endmodule

// ===== rtl/sorted_set_array_unit.sv =====
// top level: sorted set of signed keys held in a chain of compare-and-shift cells
// the input transfer sets busy; the commit raises m_tvalid with the result
// a new item is taken once the last one commits; the transfer compares the key
//   in every cell, the commit encodes the slot, shifts the chain and loads the
//   output register; a result that is not taken holds the chain until it frees
// reset (aresetn low, synchronous) empties the set and drops both channels
module sorted_set_array_unit import sas_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // cmd [1:0], key_value [33:2], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // status [2:0], position [6:3],
                                           // entry_count [11:7], zero pad
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW  = (IW > POS_W) ? IW : POS_W;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CXW = (CW > CNT_W) ? CW : CNT_W;
    localparam int M_PAD_W = M_TDATA_W - M_FIELDS_W;

    // input fields
    logic [CMD_W-1:0] s_cmd;
    logic [KEY_W-1:0] s_key;
    assign s_cmd = s_tdata[CMD_W-1:0];
    assign s_key = s_tdata[CMD_W +: KEY_W];

    // control state
    logic             busy_reg, busy_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CMD_W-1:0] cmd_reg;
    logic [KEY_W-1:0] key_reg;

    // output register
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    cnt_out_reg, cnt_out_next;

    logic capture, commit, full, any_eq;
    logic do_insert, do_remove;
    sas_ctrl_t        ctrl;
    logic [KEY_W-1:0] key_bus;
    logic [PW-1:0]    pos_wide;
    logic [CXW-1:0]   count_wide;

    // chain wiring
    logic [KEY_W-1:0] cell_value [CAPACITY];
    logic             cell_valid [CAPACITY];
    logic             cell_lt    [CAPACITY];
    logic [CAPACITY-1:0] bnd;
    logic [CAPACITY-1:0] eqv;

    assign s_tready = !busy_reg;
    assign capture  = s_tvalid && s_tready;
    assign commit   = busy_reg && (!m_tvalid_reg || m_tready);
    assign full     = (count_reg == CW'(CAPACITY));
    assign any_eq   = |eqv;

    assign do_insert = commit && (cmd_reg == CMD_INSERT) && !full && !any_eq;
    assign do_remove = commit && (cmd_reg == CMD_REMOVE) && any_eq;

    assign ctrl.capture = capture;
    assign ctrl.insert  = do_insert;
    assign ctrl.remove  = do_remove;

    // cells compare against the incoming key, insert loads the held key
    assign key_bus = busy_reg ? key_reg : s_key;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] lv, rv;
        logic             lval, llt, rval;
        if (g == 0) begin : g_first
            assign lv   = '0;
            assign lval = 1'b0;
            assign llt  = 1'b1;  // everything sits above the chain's bottom
        end else begin : g_mid
            assign lv   = cell_value[g-1];
            assign lval = cell_valid[g-1];
            assign llt  = cell_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign rv   = '0;
            assign rval = 1'b0;
        end else begin : g_inner
            assign rv   = cell_value[g+1];
            assign rval = cell_valid[g+1];
        end
        sas_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .key         (key_bus),
            .left_value  (lv),
            .left_valid  (lval),
            .left_lt     (llt),
            .right_value (rv),
            .right_valid (rval),
            .value       (cell_value[g]),
            .valid       (cell_valid[g]),
            .lt          (cell_lt[g]),
            .boundary    (bnd[g]),
            .eq          (eqv[g])
        );
    end

    // the less-than flags form a prefix, so at most one boundary is set
    always_comb begin
        pos_wide = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (bnd[i]) begin
                pos_wide = pos_wide | PW'(i);
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + CW'(1);
        end else if (do_remove) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_wide = CXW'(count_next);

    // result selection
    always_comb begin
        status_next  = ST_NOT_FOUND;
        pos_next     = '0;
        cnt_out_next = count_wide[CNT_W-1:0];
        case (cmd_reg)
            CMD_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else if (any_eq) begin
                    status_next = ST_DUPLICATE;
                end else begin
                    status_next = ST_INSERTED;
                    pos_next    = pos_wide[POS_W-1:0];
                end
            end
            CMD_REMOVE: begin
                if (any_eq) begin
                    status_next = ST_REMOVED;
                    pos_next    = pos_wide[POS_W-1:0];
                end
            end
            CMD_FIND: begin
                if (any_eq) begin
                    status_next = ST_FOUND;
                    pos_next    = pos_wide[POS_W-1:0];
                end
            end
            default: begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        if (capture) begin
            busy_next = 1'b1;
        end
        if (commit) begin
            busy_next     = 1'b0;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            cmd_reg <= s_cmd;
            key_reg <= s_key;
        end
        if (commit) begin
            status_reg  <= status_next;
            pos_reg     <= pos_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, cnt_out_reg, pos_reg, status_reg};

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_one_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> $onehot0(bnd))
        else $error("more than one insert slot in the chain");

    a_hit_at_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ((eqv & ~bnd) == '0))
        else $error("key match away from the lower bound, chain out of order");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!do_insert && !do_remove) |=> $stable(count_reg))
        else $error("entry count moved without a shift");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(busy_reg))
        else $error("result offered without an item in flight");

endmodule
